@@ rtl/core/efa_pkg.sv @@
// Package for the elementwise float adder: element type codes, format widths.
// No dependencies.
package efa_pkg;

    localparam logic [2:0] TYPE_F32 = 3'd0;
    localparam logic [2:0] TYPE_F64 = 3'd1;

    localparam logic [31:0] F32_DEFNAN = 32'h7FC0_0000;
    localparam logic [63:0] F64_DEFNAN = 64'h7FF8_0000_0000_0000;

    // Operands unpacked to a common wide form: 11-bit biased exponent, 53-bit significand.
    typedef struct packed {
        logic        valid;
        logic        last;
        logic        bad;
        logic        dbl;
        logic        special;
        logic [63:0] special_bits;
        logic        sign_l;      // sign of larger magnitude
        logic        sub;         // effective subtraction
        logic [10:0] exp_l;       // exponent of larger (>=1)
        logic [55:0] sig_l;       // significand << 3
        logic [55:0] sig_s;       // aligned smaller with guard, round, sticky
        logic        both_zero;
        logic        zero_sign;
    } st1_t;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic        bad;
        logic        dbl;
        logic        special;
        logic [63:0] special_bits;
        logic        sign;
        logic [10:0] exp_l;
        logic [56:0] sum;
        logic        both_zero;
        logic        zero_sign;
    } st2_t;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic        bad;
        logic        dbl;
        logic        special;
        logic [63:0] special_bits;
        logic        sign;
        logic [12:0] exp;         // signed-ish, biased exponent of bit 55
        logic [56:0] sig;         // normalized: leading one at bit 55
        logic        zero;
        logic        zero_sign;
    } st3_t;

endpackage

@@ rtl/core/elementwise_float_add_top.sv @@
// Top level of the elementwise IEEE 754 adder, binary32 and binary64.
// Depends on efa_pkg.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_ready, operand_a/b, last_element   | in
//  output  | out_valid, out_ready, sum_bits, last_result,    | out
//          | unsupported_type                                |
//  config  | cfg_we, cfg_wdata (element_type)                | in
//
// Five register stages: unpack/align, add, normalize, round, output.
// One transaction is accepted every cycle while the pipe advances; its result
// moves through s1, s2, s3 and s4 into the output register.
// The whole pipe advances together when the output register is empty or being
// taken, so a stall holds every stage and loses or repeats nothing.
// rst_n clears every stage and sets element_type to binary32.
module elementwise_float_add_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    input  logic        last_element,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] sum_bits,
    output logic        last_result,
    output logic        unsupported_type
);

    logic [2:0] etype_reg;
    logic       adv;

    efa_pkg::st1_t s1_reg, s1_next;
    efa_pkg::st2_t s2_reg, s2_next;
    efa_pkg::st3_t s3_reg, s3_next;
    efa_pkg::st3_t s4_reg, s4_next;   // holds rounded result in special_bits
    logic        o_valid_reg;
    logic [63:0] o_sum_reg, o_sum_next;
    logic        o_last_reg, o_bad_reg;

    // Advance the whole pipe whenever the output slot frees up.
    assign adv      = !o_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            etype_reg <= efa_pkg::TYPE_F32;
        end
        else if (cfg_we)
        begin
            etype_reg <= cfg_wdata;
        end
    end

    // ---------------- stage 1: unpack, compare, align ----------------
    always_comb
    begin
        logic        dbl, bad;
        logic        sa, sb, nan_a, nan_b, inf_a, inf_b;
        logic [10:0] ea, eb, eae, ebe;
        logic [52:0] ma, mb;
        logic        a_big;
        logic [10:0] d;
        logic [55:0] ss, sh;
        logic        sticky;
        dbl = (etype_reg == efa_pkg::TYPE_F64);
        bad = (etype_reg != efa_pkg::TYPE_F64) && (etype_reg != efa_pkg::TYPE_F32);
        if (dbl)
        begin
            sa = operand_a[63]; sb = operand_b[63];
            ea = operand_a[62:52]; eb = operand_b[62:52];
            ma = {(ea != 11'd0), operand_a[51:0]};
            mb = {(eb != 11'd0), operand_b[51:0]};
            nan_a = (ea == 11'h7FF) && (operand_a[51:0] != 52'd0);
            nan_b = (eb == 11'h7FF) && (operand_b[51:0] != 52'd0);
            inf_a = (ea == 11'h7FF) && !nan_a;
            inf_b = (eb == 11'h7FF) && !nan_b;
        end
        else
        begin
            sa = operand_a[31]; sb = operand_b[31];
            ea = {3'd0, operand_a[30:23]}; eb = {3'd0, operand_b[30:23]};
            ma = {(ea != 11'd0), operand_a[22:0], 29'd0};
            mb = {(eb != 11'd0), operand_b[22:0], 29'd0};
            nan_a = (ea == 11'h0FF) && (operand_a[22:0] != 23'd0);
            nan_b = (eb == 11'h0FF) && (operand_b[22:0] != 23'd0);
            inf_a = (ea == 11'h0FF) && !nan_a;
            inf_b = (eb == 11'h0FF) && !nan_b;
        end
        eae = (ea == 11'd0) ? 11'd1 : ea;
        ebe = (eb == 11'd0) ? 11'd1 : eb;
        a_big = {eae, ma} >= {ebe, mb};
        s1_next.valid = in_valid;
        s1_next.last  = last_element;
        s1_next.bad   = bad;
        s1_next.dbl   = dbl;
        s1_next.special = nan_a || nan_b || inf_a || inf_b;
        if (dbl)
        begin
            if (nan_a)
                s1_next.special_bits = operand_a | 64'h0008_0000_0000_0000;
            else if (nan_b)
                s1_next.special_bits = operand_b | 64'h0008_0000_0000_0000;
            else if (inf_a && inf_b && (sa != sb))
                s1_next.special_bits = efa_pkg::F64_DEFNAN;
            else if (inf_a)
                s1_next.special_bits = operand_a;
            else
                s1_next.special_bits = operand_b;
        end
        else
        begin
            if (nan_a)
                s1_next.special_bits = {32'd0, operand_a[31:0] | 32'h0040_0000};
            else if (nan_b)
                s1_next.special_bits = {32'd0, operand_b[31:0] | 32'h0040_0000};
            else if (inf_a && inf_b && (sa != sb))
                s1_next.special_bits = {32'd0, efa_pkg::F32_DEFNAN};
            else if (inf_a)
                s1_next.special_bits = {32'd0, operand_a[31:0]};
            else
                s1_next.special_bits = {32'd0, operand_b[31:0]};
        end
        s1_next.sign_l = a_big ? sa : sb;
        s1_next.sub    = sa ^ sb;
        s1_next.exp_l  = a_big ? eae : ebe;
        s1_next.sig_l  = {(a_big ? ma : mb), 3'd0};
        ss             = {(a_big ? mb : ma), 3'd0};
        d              = a_big ? (eae - ebe) : (ebe - eae);
        if (d > 11'd56)
        begin
            sh = 56'd0;
            sticky = (ss != 56'd0);
        end
        else
        begin
            sh = ss >> d[5:0];
            sticky = ((sh << d[5:0]) != ss);
        end
        s1_next.sig_s     = {sh[55:1], sh[0] | sticky};
        s1_next.both_zero = (ma == 53'd0) && (mb == 53'd0);
        s1_next.zero_sign = sa & sb;
    end

    // ---------------- stage 2: add or subtract ----------------
    always_comb
    begin
        s2_next.valid        = s1_reg.valid;
        s2_next.last         = s1_reg.last;
        s2_next.bad          = s1_reg.bad;
        s2_next.dbl          = s1_reg.dbl;
        s2_next.special      = s1_reg.special;
        s2_next.special_bits = s1_reg.special_bits;
        s2_next.sign         = s1_reg.sign_l;
        s2_next.exp_l        = s1_reg.exp_l;
        s2_next.sum          = s1_reg.sub ? ({1'b0, s1_reg.sig_l} - {1'b0, s1_reg.sig_s})
                                          : ({1'b0, s1_reg.sig_l} + {1'b0, s1_reg.sig_s});
        s2_next.both_zero    = s1_reg.both_zero;
        s2_next.zero_sign    = s1_reg.zero_sign;
    end

    // ---------------- stage 3: normalize ----------------
    always_comb
    begin
        logic [5:0]  lz;
        logic        found;
        logic [12:0] e;
        logic [56:0] m;
        lz = 6'd0;
        found = 1'b0;
        for (int i = 55; i >= 0; i--)
        begin
            if (!found && s2_reg.sum[i])
            begin
                found = 1'b1;
                lz = 6'(55 - i);
            end
        end
        e = {2'b00, s2_reg.exp_l};
        m = s2_reg.sum;
        if (m[56])
        begin
            m = {1'b0, m[56:2], m[1] | m[0]};
            e = e + 13'd1;
        end
        else if (found)
        begin
            // Stop at the minimum exponent: the value stays subnormal.
            if ({7'd0, lz} > (e - 13'd1))
            begin
                m = m << (e[5:0] - 6'd1);
                e = 13'd1;
            end
            else
            begin
                m = m << lz;
                e = e - {7'd0, lz};
            end
        end
        s3_next.valid        = s2_reg.valid;
        s3_next.last         = s2_reg.last;
        s3_next.bad          = s2_reg.bad;
        s3_next.dbl          = s2_reg.dbl;
        s3_next.special      = s2_reg.special;
        s3_next.special_bits = s2_reg.special_bits;
        s3_next.sign         = s2_reg.sign;
        s3_next.exp          = e;
        s3_next.sig          = m;
        s3_next.zero         = (s2_reg.sum == 57'd0);
        // Exact zero: -0 only when both inputs were -0.
        s3_next.zero_sign    = s2_reg.both_zero ? s2_reg.zero_sign : 1'b0;
    end

    // ---------------- stage 4: round and pack ----------------
    always_comb
    begin
        logic [53:0] keep;
        logic        g, st, lsb, up;
        logic [12:0] e;
        logic [63:0] r;
        if (s3_reg.dbl)
        begin
            keep = {1'b0, s3_reg.sig[55:3]};
            g    = s3_reg.sig[2];
            st   = s3_reg.sig[1] | s3_reg.sig[0];
        end
        else
        begin
            keep = {30'd0, s3_reg.sig[55:32]};
            g    = s3_reg.sig[31];
            st   = s3_reg.sig[30:0] != 31'd0;
        end
        lsb  = keep[0];
        up   = g && (st || lsb);
        keep = keep + {53'd0, up};
        e    = s3_reg.exp;
        if (s3_reg.dbl ? keep[53] : keep[24])
        begin
            keep = keep >> 1;
            e = e + 13'd1;
        end
        if (s3_reg.dbl ? !keep[52] : !keep[23])
        begin
            e = 13'd0;   // subnormal result
        end
        if (s3_reg.dbl)
        begin
            if (e >= 13'h7FF) r = {s3_reg.sign, 11'h7FF, 52'd0};
            else              r = {s3_reg.sign, e[10:0], keep[51:0]};
        end
        else
        begin
            if (e >= 13'h0FF) r = {32'd0, s3_reg.sign, 8'hFF, 23'd0};
            else              r = {32'd0, s3_reg.sign, e[7:0], keep[22:0]};
        end
        if (s3_reg.zero)
        begin
            r = s3_reg.dbl ? {s3_reg.zero_sign, 63'd0} : {32'd0, s3_reg.zero_sign, 31'd0};
        end
        if (s3_reg.special)
        begin
            r = s3_reg.special_bits;
        end
        s4_next = s3_reg;
        s4_next.special_bits = r;
    end

    assign o_sum_next = s4_reg.bad ? 64'd0 : s4_reg.special_bits;

    // Hold every stage on a stall; advance all together otherwise.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg      <= '0;
            s2_reg      <= '0;
            s3_reg      <= '0;
            s4_reg      <= '0;
            o_valid_reg <= 1'b0;
            o_sum_reg   <= 64'd0;
            o_last_reg  <= 1'b0;
            o_bad_reg   <= 1'b0;
        end
        else if (adv)
        begin
            s1_reg      <= s1_next;
            s2_reg      <= s2_next;
            s3_reg      <= s3_next;
            s4_reg      <= s4_next;
            o_valid_reg <= s4_reg.valid;
            o_sum_reg   <= o_sum_next;
            o_last_reg  <= s4_reg.last;
            o_bad_reg   <= s4_reg.bad;
        end
    end

    assign out_valid        = o_valid_reg;
    assign sum_bits         = o_sum_reg;
    assign last_result      = o_last_reg;
    assign unsupported_type = o_bad_reg;

endmodule

@@ tb/tb_top.sv @@
// Testbench for elementwise_float_add_top: directed table, then random phases.
// Depends on efa_pkg and the adder RTL; the sum predictor is an integer-only IEEE 754 adder.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          RAND_PHASES = 10;
    localparam int          PHASE_ITEMS = 115;
    localparam int          PIPE_DRAIN  = 8;    // five stages plus margin
    localparam logic [2:0]  TYPE_F32    = efa_pkg::TYPE_F32;
    localparam logic [2:0]  TYPE_F64    = efa_pkg::TYPE_F64;
    localparam logic [2:0]  TYPE_I32    = 3'd2;
    localparam logic [2:0]  TYPE_I64    = 3'd3;
    localparam logic [2:0]  TYPE_BOOL   = 3'd4;
    localparam logic [2:0]  TYPE_RSVD5  = 3'd5;
    localparam logic [2:0]  TYPE_RSVD   = 3'd7;

    // One result transaction as it should leave the adder.
    typedef struct {
        logic [63:0] sum;
        logic        last;
        logic        bad;
    } sum_item_t;

    // One row of the directed table; has_exp marks a typed-in expectation.
    typedef struct {
        logic [2:0]  etype;
        logic [63:0] a;
        logic [63:0] b;
        logic        last;
        logic        has_exp;
        logic [63:0] exp_sum;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic        last_element;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] sum_bits;
    logic        last_result;
    logic        unsupported_type;

    sum_item_t   pending_sums[$];
    dir_row_t    dir_rows[$];
    logic [2:0]  cur_type;
    int          fail_count = 0;
    int          rcv_count = 0;
    int          cycle_count = 0;
    bit          quiet;          // no idling on either side in the final phase

    elementwise_float_add_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operand_a        (operand_a),
        .operand_b        (operand_b),
        .last_element     (last_element),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .sum_bits         (sum_bits),
        .last_result      (last_result),
        .unsupported_type (unsupported_type)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Round-to-nearest-even addition on raw bits, binary32 (dbl=0) or binary64.
    // Three extra low bits (guard, round, sticky) keep the sum exact enough to round once.
    function automatic logic [63:0] fp_add(bit dbl, logic [63:0] a, logic [63:0] b);
        int          ew;
        int          mw;
        int          top;
        int          ea;
        int          eb;
        int          e;
        int          d;
        logic [63:0] emax;
        logic [63:0] fmask;
        logic [63:0] qbit;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] xe;
        logic [63:0] ye;
        logic [63:0] xf;
        logic [63:0] yf;
        logic [63:0] dnan;
        logic [58:0] ma;
        logic [58:0] mb;
        logic [58:0] t;
        logic [58:0] s;
        logic [58:0] keep;
        logic        sa;
        logic        sb;
        logic        g;
        logic        rest;
        ew    = dbl ? 11 : 8;
        mw    = dbl ? 52 : 23;
        top   = mw + 3;
        emax  = (64'd1 << ew) - 64'd1;
        fmask = (64'd1 << mw) - 64'd1;
        qbit  = 64'd1 << (mw - 1);
        dnan  = dbl ? efa_pkg::F64_DEFNAN : {32'b0, efa_pkg::F32_DEFNAN};
        x     = dbl ? a : {32'b0, a[31:0]};
        y     = dbl ? b : {32'b0, b[31:0]};
        sa    = x[ew + mw];
        sb    = y[ew + mw];
        xe    = (x >> mw) & emax;
        ye    = (y >> mw) & emax;
        xf    = x & fmask;
        yf    = y & fmask;
        // NaNs: first operand wins, quiet bit forced
        if (xe == emax && xf != 0)
            return x | qbit;
        if (ye == emax && yf != 0)
            return y | qbit;
        // infinities
        if (xe == emax)
            return (ye == emax && sa != sb) ? dnan : x;
        if (ye == emax)
            return y;
        // both zero: negative only when both are negative
        if (xe == 0 && xf == 0 && ye == 0 && yf == 0)
            return {63'b0, sa & sb} << (ew + mw);
        ea = (xe == 0) ? 1 : int'(xe);
        eb = (ye == 0) ? 1 : int'(ye);
        ma = 59'((xe == 0) ? xf : (xf | (64'd1 << mw))) << 3;
        mb = 59'((ye == 0) ? yf : (yf | (64'd1 << mw))) << 3;
        // order by magnitude so the larger one sets sign and exponent
        if (eb > ea || (eb == ea && mb > ma))
        begin
            t = ma; ma = mb; mb = t;
            d = ea; ea = eb; eb = d;
            g = sa; sa = sb; sb = g;
        end
        d = ea - eb;
        if (d > mw + 5)
            t = (mb != 0) ? 59'd1 : 59'd0;
        else
        begin
            t = mb >> d;
            if ((t << d) != mb)
                t = t | 59'd1;
        end
        s = (sa != sb) ? ma - t : ma + t;
        if (s == 0)
            return 64'd0;
        e = ea;
        if (s[top + 1])
        begin
            s = (s >> 1) | {58'b0, s[0]};
            e = e + 1;
        end
        else
        begin
            while (!s[top] && e > 1)
            begin
                s = s << 1;
                e = e - 1;
            end
        end
        g    = s[2];
        rest = s[1] | s[0];
        keep = s >> 3;
        if (g && (rest || keep[0]))
            keep = keep + 59'd1;
        if (keep[mw + 1])
        begin
            keep = keep >> 1;
            e = e + 1;
        end
        if (e >= int'(emax))
            return ({63'b0, sa} << (ew + mw)) | (emax << mw);
        return ({63'b0, sa} << (ew + mw))
             | ((keep[mw] ? 64'(e) : 64'd0) << mw)
             | (64'(keep) & fmask);
    endfunction

    function automatic sum_item_t predict_sum(logic [2:0] etype, logic [63:0] a,
                                              logic [63:0] b, logic last);
        sum_item_t r;
        r.last = last;
        r.bad  = !(etype == TYPE_F32 || etype == TYPE_F64);
        r.sum  = r.bad ? 64'd0 : fp_add(etype == TYPE_F64, a, b);
        return r;
    endfunction

    // Build an operand from fields; binary32 gets random junk in the upper half.
    function automatic logic [63:0] pack_fp(bit dbl, logic sgn, logic [63:0] ex,
                                            logic [63:0] fr);
        if (dbl)
            return {sgn, ex[10:0], fr[51:0]};
        return {32'($urandom), sgn, ex[7:0], fr[22:0]};
    endfunction

    // Mix of shapes: raw random, zeros, infinities, NaNs, subnormals, near-maximum,
    // and exponents close to the other operand so cancellation and carries occur.
    function automatic logic [63:0] pick_operand(bit dbl, logic [63:0] other);
        logic [63:0] emax;
        logic [63:0] fr;
        logic [63:0] oe;
        int          ne;
        emax = dbl ? 64'h7FF : 64'hFF;
        fr   = {32'($urandom), 32'($urandom)};
        oe   = dbl ? {53'b0, other[62:52]} : {56'b0, other[30:23]};
        case ($urandom_range(0, 9))
            0, 1: return {32'($urandom), 32'($urandom)};
            2:    return pack_fp(dbl, 1'($urandom), 64'd0, 64'd0);
            3:    return pack_fp(dbl, 1'($urandom), emax, 64'd0);
            4:    return pack_fp(dbl, 1'($urandom), emax, fr | 64'd1);
            5:    return pack_fp(dbl, 1'($urandom), 64'd0, fr);
            6:    return pack_fp(dbl, 1'($urandom), emax - 64'($urandom_range(1, 2)),
                                 ($urandom_range(0, 1) != 0) ? ~64'd0 : fr);
            default:
            begin
                ne = int'(oe) + $urandom_range(0, 6) - 3;
                if (ne < 0)
                    ne = 0;
                if (ne >= int'(emax))
                    ne = int'(emax) - 1;
                // sometimes share the fraction for exact or near cancellation
                if ($urandom_range(0, 2) == 0)
                    fr = other ^ 64'($urandom_range(0, 3));
                return pack_fp(dbl, 1'($urandom), 64'(ne), fr);
            end
        endcase
    endfunction

    task automatic add_row(logic [2:0] t, logic [63:0] a, logic [63:0] b, logic last,
                           logic has, logic [63:0] es);
        dir_row_t r;
        r.etype = t; r.a = a; r.b = b; r.last = last; r.has_exp = has; r.exp_sum = es;
        dir_rows.push_back(r);
    endtask

    // Change the element type only with the pipe empty: drop valid, wait for every
    // pending sum, let the pipe settle, then write the register for one cycle.
    task automatic set_type(logic [2:0] t);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= t;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_type = t;
    endtask

    // Offer one transaction and hold it until accepted; the expectation is queued
    // at the accepting edge. Valid stays high afterwards so back-to-back items
    // never see valid dropped and raised in one step.
    task automatic send_pair(logic [63:0] a, logic [63:0] b, logic last, logic has,
                             logic [63:0] es);
        sum_item_t p;
        in_valid     <= 1'b1;
        operand_a    <= a;
        operand_b    <= b;
        last_element <= last;
        do
            @(posedge clk);
        while (!in_ready);
        p = predict_sum(cur_type, a, b, last);
        if (has)
            p.sum = es;
        pending_sums.push_back(p);
    endtask

    // Random idle burst on the sender side.
    task automatic maybe_idle();
        int n;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Receiver: check every accepted result against the oldest expectation, then
    // choose out_ready for the next cycle. One long hold-off fills the pipe.
    initial
    begin : receiver
        int        stall_left;
        int        hold_left;
        bit        held_once;
        sum_item_t want;
        stall_left = 0;
        hold_left  = 0;
        held_once  = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                rcv_count = rcv_count + 1;
                if (pending_sums.size() == 0)
                begin
                    $error("result with no pending sum: sum_bits=%h", sum_bits);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = pending_sums.pop_front();
                    if (sum_bits !== want.sum)
                    begin
                        $error("sum_bits: expected %h, got %h", want.sum, sum_bits);
                        fail_count = fail_count + 1;
                    end
                    if (last_result !== want.last)
                    begin
                        $error("last_result: expected %b, got %b", want.last, last_result);
                        fail_count = fail_count + 1;
                    end
                    if (unsupported_type !== want.bad)
                    begin
                        $error("unsupported_type: expected %b, got %b",
                               want.bad, unsupported_type);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (!held_once && rcv_count >= 200)
            begin
                held_once = 1;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left  = hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Sender: reset, directed table, random phases, drain, verdict.
    initial
    begin : sender
        logic [2:0]  t;
        logic [63:0] a;
        logic [63:0] b;
        logic [2:0]  phase_types [RAND_PHASES];
        cfg_we       = 1'b0;
        cfg_wdata    = TYPE_F32;
        in_valid     = 1'b0;
        operand_a    = 64'd0;
        operand_b    = 64'd0;
        last_element = 1'b0;
        rst_n        = 1'b0;
        cur_type     = TYPE_F32;
        quiet        = 0;
        phase_types  = '{TYPE_F32, TYPE_F64, TYPE_F32, TYPE_F64, TYPE_RSVD5,
                         TYPE_F32, TYPE_F64, TYPE_I64, TYPE_F64, TYPE_F32};

        // binary32 after reset, no register write yet
        add_row(TYPE_F32, 64'h3F80_0000, 64'h3F80_0000, 1'b0, 1'b1, 64'h4000_0000);
        add_row(TYPE_F32, 64'hFFFF_FFFF_3F80_0000, 64'hAAAA_AAAA_0000_0000, 1'b1, 1'b1,
                64'h3F80_0000);                                    // upper halves ignored
        add_row(TYPE_F32, 64'h7F80_0000, 64'hFF80_0000, 1'b0, 1'b1, 64'h7FC0_0000);
        add_row(TYPE_F32, 64'h7F80_0001, 64'h7F80_0002, 1'b0, 1'b1, 64'h7FC0_0001);
        add_row(TYPE_F32, 64'h0000_0000, 64'hFF80_0010, 1'b1, 1'b1, 64'hFFC0_0010);
        add_row(TYPE_F32, 64'h7F7F_FFFF, 64'h7F7F_FFFF, 1'b0, 1'b1, 64'h7F80_0000);
        add_row(TYPE_F32, 64'h0000_0001, 64'h0000_0001, 1'b0, 1'b1, 64'h0000_0002);
        add_row(TYPE_F32, 64'h8000_0000, 64'h8000_0000, 1'b0, 1'b1, 64'h8000_0000);
        add_row(TYPE_F32, 64'h0000_0000, 64'h8000_0000, 1'b0, 1'b1, 64'h0000_0000);
        add_row(TYPE_F32, 64'h3F80_0000, 64'hBF80_0000, 1'b0, 1'b1, 64'h0000_0000);
        add_row(TYPE_F32, 64'h3F80_0001, 64'hB380_0000, 1'b0, 1'b0, 64'd0);
        add_row(TYPE_F32, 64'h4B7F_FFFF, 64'h3F00_0000, 1'b1, 1'b0, 64'd0);
        // binary64
        add_row(TYPE_F64, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b0, 1'b1,
                64'h4000_0000_0000_0000);
        add_row(TYPE_F64, 64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 1'b0, 1'b1,
                64'h7FF8_0000_0000_0000);
        add_row(TYPE_F64, 64'h7FF0_0000_0000_0001, 64'h3FF0_0000_0000_0000, 1'b1, 1'b1,
                64'h7FF8_0000_0000_0001);
        add_row(TYPE_F64, 64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
                64'h7FF0_0000_0000_0000);
        add_row(TYPE_F64, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 1'b0, 1'b1,
                64'hFFFF_FFFF_FFFF_FFFF);
        add_row(TYPE_F64, 64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF, 1'b0, 1'b1,
                64'h0010_0000_0000_0000);
        add_row(TYPE_F64, 64'h3FF0_0000_0000_0001, 64'hBCA0_0000_0000_0000, 1'b1, 1'b0,
                64'd0);
        // unsupported types, code 7 as the top extreme
        add_row(TYPE_I32, 64'h3F80_0000, 64'h3F80_0000, 1'b1, 1'b1, 64'd0);
        add_row(TYPE_I64, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 1'b0, 1'b1, 64'd0);
        add_row(TYPE_BOOL, 64'd1, 64'd1, 1'b1, 1'b1, 64'd0);
        add_row(TYPE_RSVD, 64'h7FF0_0000_0000_0001, 64'd0, 1'b0, 1'b1, 64'd0);

        // hold reset, then release it at a clock edge
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].etype != cur_type)
                set_type(dir_rows[i].etype);
            send_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].last,
                      dir_rows[i].has_exp, dir_rows[i].exp_sum);
            maybe_idle();
        end

        // random phases; the last one runs with no idling at all
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            t = phase_types[ph];
            set_type(t);
            if (ph == RAND_PHASES - 1)
                quiet = 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                a = pick_operand(t == TYPE_F64, {32'($urandom), 32'($urandom)});
                b = pick_operand(t == TYPE_F64, a);
                if ($urandom_range(0, 1) != 0)
                begin
                    a = a ^ b;
                    b = a ^ b;
                    a = a ^ b;
                end
                send_pair(a, b, 1'($urandom), 1'b0, 64'd0);
                maybe_idle();
            end
        end

        in_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN * 3) @(posedge clk);
        if (fail_count == 0 && pending_sums.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
